[design/orhr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orhr_pkg
// Shared types and constants of the onion relay header rewrite block.
// ----------------------------------------------------------------------------
package orhr_pkg;

  // default number of hop slots in a relay header
  localparam int HOP_SLOTS_DEF = 5;

  // header layout
  localparam int HDR_FIXED_BYTES = 87;
  localparam int SLOT_BYTES      = 16;
  localparam int SLOT_W          = 3;

  // word indices inside the stored header
  localparam int WORD_MAC0  = 0;
  localparam int WORD_MAC1  = 1;
  localparam int WORD_NH    = 2;
  localparam int WORD_DST0  = 4;
  localparam int WORD_DST1  = 5;
  localparam int WORD_DST2  = 6;
  localparam int WORD_MAGIC = 9;
  localparam int WORD_HOP   = 10;
  localparam int SRC_WORD0  = HDR_FIXED_BYTES / 8;

  // number of steps of the slot fetch (three reads, one trailing capture)
  localparam int FETCH_STEPS = 4;

  // protocol constants
  localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  NEXT_HDR_TCP   = 8'd6;

  // configuration registers
  localparam int          PADDR_W     = 3;
  localparam logic [31:0] MAGIC_RESET = 32'h3136_5856;
  localparam logic [7:0]  KIND_RESET  = 8'd5;
  localparam logic        REG_MAGIC   = 1'b0;
  localparam logic        REG_KIND    = 1'b1;

  typedef logic [63:0] word_t;

  // write-back steps of the rewrite
  typedef enum logic [2:0] {
    WS_MAC0 = 3'd0,
    WS_MAC1 = 3'd1,
    WS_DST0 = 3'd2,
    WS_DST1 = 3'd3,
    WS_DST2 = 3'd4,
    WS_HOP  = 3'd5
  } wr_step_t;

  // header fields captured while the header streams in
  typedef struct packed {
    word_t        mac0;
    word_t        mac1;
    logic [7:0]   next_hdr;
    logic [31:0]  magic;
    logic [7:0]   kind;
    logic [47:0]  dst_hi;
    logic [15:0]  dst_lo;
    word_t        hop_word;
  } hdr_fields_t;

  // verdict of the header check
  typedef struct packed {
    logic              verdict;
    logic [SLOT_W-1:0] slot;
  } judge_t;

  // zero or above eight counts as eight
  function automatic logic [3:0] norm_bytes(input logic [3:0] nb);
    norm_bytes = (nb == 4'd0 || nb > 4'd8) ? 4'd8 : nb;
  endfunction

endpackage

[design/orhr_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orhr_in_if / orhr_out_if
// Valid/ready word channels of the header rewrite block.
// ----------------------------------------------------------------------------
interface orhr_in_if import orhr_pkg::*; ();
  logic       valid;
  logic       ready;
  word_t      in_word;
  logic [3:0] in_bytes;
  logic       in_last;

  modport source (output valid, output in_word, output in_bytes, output in_last,
                  input ready);
  modport sink   (input valid, input in_word, input in_bytes, input in_last,
                  output ready);
endinterface

interface orhr_out_if import orhr_pkg::*; ();
  logic       valid;
  logic       ready;
  word_t      out_word;
  logic [3:0] out_bytes;
  logic       out_last;
  logic       transmit;

  modport source (output valid, output out_word, output out_bytes, output out_last,
                  output transmit, input ready);
  modport sink   (input valid, input out_word, input out_bytes, input out_last,
                  input transmit, output ready);
endinterface

[design/orhr_judge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orhr_judge
// Relay header check and merge unit that builds each rewritten header word.
// ----------------------------------------------------------------------------
module orhr_judge import orhr_pkg::*; #(
  parameter int HOP_SLOTS = HOP_SLOTS_DEF
) (
  input  hdr_fields_t  hdr,
  input  logic         full,
  input  logic [31:0]  magic_cfg,
  input  logic [7:0]   kind_cfg,
  input  logic [127:0] src,
  input  wr_step_t     step,
  output judge_t       st,
  output word_t        wr_data
);

  logic [31:0] hop;
  logic [31:0] hop_inc;

  // little-endian hop count at bytes 83..86
  assign hop     = {hdr.hop_word[15:8], hdr.hop_word[23:16],
                    hdr.hop_word[31:24], hdr.hop_word[39:32]};
  assign hop_inc = hop + 32'd1;

  // relay packet check
  assign st.verdict = full &&
                      (hdr.mac1[31:16] == ETHERTYPE_IPV6) &&
                      (hdr.next_hdr == NEXT_HDR_TCP) &&
                      (hdr.magic == magic_cfg) &&
                      (hdr.kind == kind_cfg) &&
                      (hop < 32'(HOP_SLOTS - 1));
  assign st.slot = hop[SLOT_W-1:0] + SLOT_W'(1);

  // merge of captured words and fetched slot bytes
  always_comb begin
    unique case (step)
      WS_MAC0: wr_data = {hdr.mac0[15:0], hdr.mac1[63:32], hdr.mac0[63:48]};
      WS_MAC1: wr_data = {hdr.mac0[47:16], hdr.mac1[31:0]};
      WS_DST0: wr_data = {hdr.dst_hi, src[127:112]};
      WS_DST1: wr_data = src[111:48];
      WS_DST2: wr_data = {src[47:0], hdr.dst_lo};
      WS_HOP:  wr_data = {hdr.hop_word[63:40], hop_inc[7:0], hop_inc[15:8],
                          hop_inc[23:16], hop_inc[31:24], hdr.hop_word[7:0]};
      default: wr_data = hdr.mac0;
    endcase
  end

endmodule

[design/onion_relay_header_rewrite.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onion_relay_header_rewrite
// Buffers the relay header of each frame, checks it and rewrites it in place.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  in_ch     in   valid / ready       in_word, in_bytes, in_last
//  out_ch    out  valid / ready       out_word, out_bytes, out_last, transmit
//  cfg       in   psel/penable/pready paddr, pwdata, prdata (protocol_magic, relay_kind)
//
//  header words are taken one a cycle into the header memory; the collected
//  header then goes through the check state, and on a relay frame through the
//  slot fetch and six word write-backs on the single write port of the header memory.
//  each burst word passes the registered memory read, then the output
//  register; words after the header pass at one per cycle while the output is free.
//  rst_n is synchronous; the header memory is not cleared.
//  a stalled output holds the burst and blocks input until the frame tail.
// ----------------------------------------------------------------------------
module onion_relay_header_rewrite import orhr_pkg::*; #(
  parameter int HOP_SLOTS = HOP_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  orhr_in_if.sink            in_ch,
  orhr_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int HDR_BYTES = HDR_FIXED_BYTES + SLOT_BYTES * HOP_SLOTS;
  localparam int HDR_WORDS = (HDR_BYTES + 7) / 8;
  localparam int AW        = $clog2(HDR_WORDS);
  localparam int LAST_MIN  = HDR_BYTES - 8 * (HDR_WORDS - 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(HDR_WORDS - 1);

  typedef enum logic [5:0] {
    S_COLLECT = 6'b000001,
    S_JUDGE   = 6'b000010,
    S_FETCH   = 6'b000100,
    S_WRITE   = 6'b001000,
    S_DRAIN   = 6'b010000,
    S_PASS    = 6'b100000
  } state_t;

  // control state
  state_t        state_r, state_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] last_idx_r, last_idx_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [2:0]    step_r, step_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          verdict_r, verdict_nxt;
  logic          full_r, full_nxt;
  logic          last_r, last_nxt;
  logic [3:0]    tail_r, tail_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   magic_r;
  logic [7:0]    kind_r;

  // payload state
  hdr_fields_t   hdr_r, hdr_nxt;
  logic [127:0]  src_r, src_nxt;
  word_t         out_word_r, out_word_nxt;
  logic [3:0]    out_bytes_r, out_bytes_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_tx_r, out_tx_nxt;

  // header memory
  word_t         hdr_mem [HDR_WORDS];
  word_t         rd_data_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  word_t         mem_wdata;

  logic          acc_in, out_free;
  logic [3:0]    nb;
  judge_t        judge_st;
  word_t         merge_word;
  wr_step_t      wstep;

  assign acc_in   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign nb       = norm_bytes(in_ch.in_bytes);
  assign wstep    = wr_step_t'(step_r);

  assign in_ch.ready = (state_r == S_COLLECT) || ((state_r == S_PASS) && out_free);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_word  = out_word_r;
  assign out_ch.out_bytes = out_bytes_r;
  assign out_ch.out_last  = out_last_r;
  assign out_ch.transmit  = out_tx_r;

  // check and merge unit
  orhr_judge #(
    .HOP_SLOTS (HOP_SLOTS)
  ) u_judge (
    .hdr       (hdr_r),
    .full      (full_r),
    .magic_cfg (magic_r),
    .kind_cfg  (kind_r),
    .src       (src_r),
    .step      (wstep),
    .st        (judge_st),
    .wr_data   (merge_word)
  );

  // configuration registers
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_MAGIC: prdata = magic_r;
      REG_KIND:  prdata = {24'd0, kind_r};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= MAGIC_RESET;
      kind_r  <= KIND_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_MAGIC) magic_r <= pwdata;
      else                       kind_r  <= pwdata[7:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    last_idx_nxt  = last_idx_r;
    k_nxt         = k_r;
    base_nxt      = base_r;
    step_nxt      = step_r;
    rd_pend_nxt   = rd_pend_r;
    verdict_nxt   = verdict_r;
    full_nxt      = full_r;
    last_nxt      = last_r;
    tail_nxt      = tail_r;
    hdr_nxt       = hdr_r;
    src_nxt       = src_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_word_nxt  = out_word_r;
    out_bytes_nxt = out_bytes_r;
    out_last_nxt  = out_last_r;
    out_tx_nxt    = out_tx_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = in_ch.in_word;
    mem_raddr     = k_r;

    unique case (state_r)
      // store header words, keep the fields the check needs
      S_COLLECT: begin
        if (acc_in) begin
          mem_we  = 1'b1;
          pos_nxt = pos_r + AW'(1);
          if (pos_r == AW'(WORD_MAC0))  hdr_nxt.mac0     = in_ch.in_word;
          if (pos_r == AW'(WORD_MAC1))  hdr_nxt.mac1     = in_ch.in_word;
          if (pos_r == AW'(WORD_NH))    hdr_nxt.next_hdr = in_ch.in_word[31:24];
          if (pos_r == AW'(WORD_DST0))  hdr_nxt.dst_hi   = in_ch.in_word[63:16];
          if (pos_r == AW'(WORD_DST2))  hdr_nxt.dst_lo   = in_ch.in_word[15:0];
          if (pos_r == AW'(WORD_MAGIC)) begin
            hdr_nxt.magic = in_ch.in_word[47:16];
            hdr_nxt.kind  = in_ch.in_word[15:8];
          end
          if (pos_r == AW'(WORD_HOP))   hdr_nxt.hop_word = in_ch.in_word;
          if (in_ch.in_last || pos_r == LAST_IDX) begin
            last_idx_nxt = pos_r;
            tail_nxt     = nb;
            last_nxt     = in_ch.in_last;
            full_nxt     = (pos_r == LAST_IDX) &&
                           (!in_ch.in_last || nb >= 4'(LAST_MIN));
            pos_nxt      = '0;
            state_nxt    = S_JUDGE;
          end
        end
      end
      // check the collected header
      S_JUDGE: begin
        verdict_nxt = judge_st.verdict;
        base_nxt    = AW'(SRC_WORD0) + AW'({judge_st.slot, 1'b0});
        step_nxt    = '0;
        k_nxt       = '0;
        rd_pend_nxt = 1'b0;
        state_nxt   = judge_st.verdict ? S_FETCH : S_DRAIN;
      end
      // read the three words that hold the chosen slot
      S_FETCH: begin
        if (step_r < 3'd3) begin
          mem_re    = 1'b1;
          mem_raddr = base_r + AW'(step_r);
        end
        unique case (step_r)
          3'd1:    src_nxt[127:120] = rd_data_r[7:0];
          3'd2:    src_nxt[119:56]  = rd_data_r;
          3'd3:    src_nxt[55:0]    = rd_data_r[63:8];
          default: ;
        endcase
        step_nxt = step_r + 3'd1;
        if (step_r == 3'(FETCH_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_WRITE;
        end
      end
      // write the rewritten words back, one a cycle
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = merge_word;
        unique case (wstep)
          WS_MAC0: mem_waddr = AW'(WORD_MAC0);
          WS_MAC1: mem_waddr = AW'(WORD_MAC1);
          WS_DST0: mem_waddr = AW'(WORD_DST0);
          WS_DST1: mem_waddr = AW'(WORD_DST1);
          WS_DST2: mem_waddr = AW'(WORD_DST2);
          WS_HOP:  mem_waddr = AW'(WORD_HOP);
          default: mem_we    = 1'b0;
        endcase
        step_nxt = step_r + 3'd1;
        if (wstep == WS_HOP) begin
          step_nxt  = '0;
          state_nxt = S_DRAIN;
        end
      end
      // emit the stored burst
      S_DRAIN: begin
        if (!rd_pend_r) begin
          mem_re      = 1'b1;
          mem_raddr   = k_r;
          rd_pend_nxt = 1'b1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = rd_data_r;
          out_bytes_nxt = (k_r == last_idx_r) ? tail_r : 4'd8;
          out_last_nxt  = (k_r == last_idx_r) && last_r;
          out_tx_nxt    = verdict_r;
          rd_pend_nxt   = 1'b0;
          k_nxt         = k_r + AW'(1);
          if (k_r == last_idx_r) begin
            k_nxt = '0;
            if (last_r) begin
              verdict_nxt = 1'b0;
              state_nxt   = S_COLLECT;
            end else begin
              state_nxt = S_PASS;
            end
          end
        end
      end
      // rest of the frame, one for one
      S_PASS: begin
        if (acc_in) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = in_ch.in_word;
          out_bytes_nxt = nb;
          out_last_nxt  = in_ch.in_last;
          out_tx_nxt    = verdict_r;
          if (in_ch.in_last) begin
            verdict_nxt = 1'b0;
            state_nxt   = S_COLLECT;
          end
        end
      end
      default: state_nxt = S_COLLECT;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      pos_r       <= '0;
      last_idx_r  <= '0;
      k_r         <= '0;
      base_r      <= '0;
      step_r      <= '0;
      rd_pend_r   <= 1'b0;
      verdict_r   <= 1'b0;
      full_r      <= 1'b0;
      last_r      <= 1'b0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      last_idx_r  <= last_idx_nxt;
      k_r         <= k_nxt;
      base_r      <= base_nxt;
      step_r      <= step_nxt;
      rd_pend_r   <= rd_pend_nxt;
      verdict_r   <= verdict_nxt;
      full_r      <= full_nxt;
      last_r      <= last_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hdr_r       <= hdr_nxt;
    src_r       <= src_nxt;
    out_word_r  <= out_word_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_last_r  <= out_last_nxt;
    out_tx_r    <= out_tx_nxt;
  end

  // header memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) hdr_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= hdr_mem[mem_raddr];
  end

  // checks
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COLLECT) |-> (pos_r <= LAST_IDX))
    else $error("header write position beyond header store");

  a_rewrite_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH || state_r == S_WRITE) |-> (full_r && verdict_r))
    else $error("rewrite started on a short or rejected header");

  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> (k_r <= last_idx_r))
    else $error("burst index beyond last stored word");

  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_JUDGE) |=> !acc_in)
    else $error("transaction taken while header is being processed");

endmodule

[dv/onion_relay_header_rewrite_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onion_relay_header_rewrite_tb
// Streams relay-shaped, truncated, runt and noise frames through the header
// rewrite block while the protocol registers are stepped through several
// settings. An in-bench predictor works out each emitted word, and a
// scoreboard compares every output transaction with it field by field.
// ----------------------------------------------------------------------------
module onion_relay_header_rewrite_tb;
  import orhr_pkg::*;

  localparam int HOP_SLOTS     = HOP_SLOTS_DEF;
  localparam int HDR_BYTES     = HDR_FIXED_BYTES + SLOT_BYTES * HOP_SLOTS;
  localparam int HDR_WORDS     = (HDR_BYTES + 7) / 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_WORDS  = 260;
  localparam int PHASES        = 4;
  localparam int MAX_REPORTS   = 10;

  // byte offsets of the relay header fields
  localparam int ETH_TYPE_OFS = 12;
  localparam int NEXT_HDR_OFS = 20;
  localparam int DST_OFS      = 38;
  localparam int MAGIC_OFS    = 74;
  localparam int KIND_OFS     = 78;
  localparam int HOP_OFS      = 83;

  // ways a relay-shaped header is spoilt
  typedef enum int {
    BRK_NONE,
    BRK_ETHERTYPE,
    BRK_NEXT_HDR,
    BRK_MAGIC,
    BRK_KIND
  } header_break_e;

  typedef struct packed {
    word_t      word;
    logic [3:0] nbytes;
    logic       last;
    logic       transmit;
  } out_beat_t;

  // predictor of the emitted words plus the queue of words still due
  class relay_checker;
    word_t       hdr_words [HDR_WORDS];
    int unsigned word_pos;
    logic [3:0]  tail_nb;
    logic        held_verdict;
    bit          in_body;
    logic [31:0] magic_reg;
    logic [7:0]  kind_reg;
    out_beat_t   due_words [$];
    int unsigned failures;

    function new();
      word_pos     = 0;
      tail_nb      = 4'd0;
      held_verdict = 1'b0;
      in_body      = 1'b0;
      magic_reg    = MAGIC_RESET;
      kind_reg     = KIND_RESET;
      failures     = 0;
    endfunction

    function void load_register(logic idx, logic [31:0] value);
      if (idx == REG_MAGIC) begin
        magic_reg = value;
      end else begin
        kind_reg = value[7:0];
      end
    endfunction

    function logic [7:0] hdr_byte(int unsigned i);
      if ((i >> 3) >= HDR_WORDS) return 8'h00;
      return hdr_words[i >> 3][63 - 8 * (i % 8) -: 8];
    endfunction

    function void set_hdr_byte(int unsigned i, logic [7:0] v);
      if ((i >> 3) < HDR_WORDS) hdr_words[i >> 3][63 - 8 * (i % 8) -: 8] = v;
    endfunction

    // header check, with the in-place rewrite of a relay frame
    function logic judge_and_rewrite();
      logic [31:0] hop;
      logic [31:0] slot;
      logic [31:0] magic;
      int unsigned src;
      logic [7:0]  t;
      int          k;
      if ({hdr_byte(ETH_TYPE_OFS), hdr_byte(ETH_TYPE_OFS + 1)} != ETHERTYPE_IPV6) return 1'b0;
      if (hdr_byte(NEXT_HDR_OFS) != NEXT_HDR_TCP) return 1'b0;
      magic = {hdr_byte(MAGIC_OFS), hdr_byte(MAGIC_OFS + 1),
               hdr_byte(MAGIC_OFS + 2), hdr_byte(MAGIC_OFS + 3)};
      if (magic != magic_reg || hdr_byte(KIND_OFS) != kind_reg) return 1'b0;
      hop = {hdr_byte(HOP_OFS + 3), hdr_byte(HOP_OFS + 2),
             hdr_byte(HOP_OFS + 1), hdr_byte(HOP_OFS)};
      if (hop >= HOP_SLOTS - 1) return 1'b0;
      slot = hop + 1;
      // hop count back, little-endian
      for (k = 0; k < 4; k++) set_hdr_byte(HOP_OFS + k, slot[8 * k +: 8]);
      // next hop address into the ipv6 destination
      src = HDR_FIXED_BYTES + SLOT_BYTES * slot;
      for (k = 0; k < 16; k++) set_hdr_byte(DST_OFS + k, hdr_byte(src + k));
      // swap destination and source mac
      for (k = 0; k < 6; k++) begin
        t = hdr_byte(k);
        set_hdr_byte(k, hdr_byte(6 + k));
        set_hdr_byte(6 + k, t);
      end
      return 1'b1;
    endfunction

    // accepted input transaction: predict whatever it releases
    function void absorb_word(word_t w, logic [3:0] raw_nb, logic last);
      logic [3:0]  nb;
      int unsigned count;
      int unsigned length;
      logic        verdict;
      int unsigned k;
      nb = (raw_nb == 4'd0 || raw_nb > 4'd8) ? 4'd8 : raw_nb;
      if (in_body) begin
        due_words.push_back(out_beat_t'{w, nb, last, held_verdict});
        if (last) begin
          in_body      = 1'b0;
          held_verdict = 1'b0;
          word_pos     = 0;
        end
        return;
      end
      if (word_pos < HDR_WORDS) hdr_words[word_pos] = w;
      word_pos++;
      tail_nb = nb;
      if (!last && word_pos < HDR_WORDS) return;
      count   = (word_pos > HDR_WORDS) ? HDR_WORDS : word_pos;
      length  = 8 * (count - 1) + (last ? nb : 8);
      verdict = 1'b0;
      if (count == HDR_WORDS && length >= HDR_BYTES) verdict = judge_and_rewrite();
      // header burst
      for (k = 0; k < count; k++) begin
        due_words.push_back(out_beat_t'{hdr_words[k], (k + 1 == count) ? tail_nb : 4'd8,
                                        (k + 1 == count) && last, verdict});
      end
      word_pos     = 0;
      in_body      = !last;
      held_verdict = last ? 1'b0 : verdict;
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // accepted output transaction against the oldest word due
    function void check_emitted(out_beat_t got);
      out_beat_t want;
      if (due_words.size() == 0) begin
        note_failure($sformatf("unexpected word %h bytes %0d last %0b transmit %0b",
                               got.word, got.nbytes, got.last, got.transmit));
        return;
      end
      want = due_words.pop_front();
      if (got.word !== want.word || got.nbytes !== want.nbytes ||
          got.last !== want.last || got.transmit !== want.transmit) begin
        note_failure($sformatf({"expected word %h bytes %0d last %0b transmit %0b, ",
                                "got word %h bytes %0d last %0b transmit %0b"},
                               want.word, want.nbytes, want.last, want.transmit,
                               got.word, got.nbytes, got.last, got.transmit));
      end
    endfunction

    function int unsigned pending();
      return due_words.size();
    endfunction

    function void close_out();
      if (due_words.size() != 0)
        note_failure($sformatf("%0d words never emitted", due_words.size()));
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  orhr_in_if  in_if ();
  orhr_out_if out_if ();

  relay_checker relay_chk = new();

  bit          gaps_on = 1'b1;
  int unsigned words_sent;
  int unsigned cycle_count = 0;
  logic [7:0]  frame_buf [256];
  int          frame_len;

  onion_relay_header_rewrite #(
    .HOP_SLOTS(HOP_SLOTS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .psel   (cfg_psel),
    .penable(cfg_penable),
    .pwrite (cfg_pwrite),
    .paddr  (cfg_paddr),
    .pwdata (cfg_pwdata),
    .prdata (cfg_prdata),
    .pready (cfg_pready)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // output transaction monitor
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      relay_chk.check_emitted(out_beat_t'{out_if.out_word, out_if.out_bytes,
                                          out_if.out_last, out_if.transmit});
    end
  end

  // receiver back-pressure in bursts
  initial begin
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  // one input transaction, with an optional idle burst ahead of it
  task automatic send_word(input word_t w, input logic [3:0] nb, input logic last);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.in_word  <= w;
    in_if.in_bytes <= nb;
    in_if.in_last  <= last;
    do @(posedge clk); while (!in_if.ready);
    relay_chk.absorb_word(w, nb, last);
    words_sent++;
  endtask

  // register write: setup then access phase
  task automatic write_register(input logic idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    relay_chk.load_register(idx, value);
    @(posedge clk);
  endtask

  // stop sending and let every due word drain, then allow for the pipeline
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (relay_chk.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // hop count mostly in range, sometimes at the last slot or far beyond
  function automatic logic [31:0] pick_hop();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, HOP_SLOTS - 2);
    if (r == 7) return HOP_SLOTS - 1;
    if (r == 8) return $urandom | 32'h0000_0100;
    return 32'hFFFF_FFFF;
  endfunction

  // random bytes, optionally shaped into a relay header
  task automatic build_frame(input int len, input bit shaped, input logic [31:0] hop,
                             input header_break_e brk);
    int          i;
    logic [31:0] magic;
    magic = relay_chk.magic_reg;
    frame_len = len;
    for (i = 0; i < 256; i++) frame_buf[i] = 8'($urandom);
    if (!shaped) return;
    frame_buf[ETH_TYPE_OFS]     = ETHERTYPE_IPV6[15:8];
    frame_buf[ETH_TYPE_OFS + 1] = ETHERTYPE_IPV6[7:0];
    frame_buf[NEXT_HDR_OFS]     = NEXT_HDR_TCP;
    for (i = 0; i < 4; i++) frame_buf[MAGIC_OFS + i] = magic[31 - 8 * i -: 8];
    frame_buf[KIND_OFS] = relay_chk.kind_reg;
    for (i = 0; i < 4; i++) frame_buf[HOP_OFS + i] = hop[8 * i +: 8];
    case (brk)
      BRK_ETHERTYPE: begin
        frame_buf[ETH_TYPE_OFS + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      end
      BRK_NEXT_HDR: begin
        frame_buf[NEXT_HDR_OFS] ^= 8'($urandom_range(1, 255));
      end
      BRK_MAGIC: begin
        frame_buf[MAGIC_OFS + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
      end
      BRK_KIND: begin
        frame_buf[KIND_OFS] ^= 8'($urandom_range(1, 255));
      end
      default: ;
    endcase
  endtask

  // frame buffer out as words; odd byte counts now and then
  task automatic send_frame();
    int         nwords;
    int         i;
    int         k;
    int         rem;
    word_t      w;
    logic [3:0] nb;
    nwords = (frame_len + 7) / 8;
    for (i = 0; i < nwords; i++) begin
      for (k = 0; k < 8; k++) w[63 - 8 * k -: 8] = frame_buf[8 * i + k];
      if (i == nwords - 1) begin
        rem = frame_len - 8 * i;
        nb  = 4'(rem);
        if (rem == 8 && $urandom_range(0, 3) == 0)
          nb = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
      end else begin
        nb = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
      end
      send_word(w, nb, i == nwords - 1);
    end
  endtask

  task automatic random_frame();
    int            r;
    header_break_e brk;
    r   = $urandom_range(0, 19);
    brk = BRK_NONE;
    if ($urandom_range(0, 3) == 0) brk = header_break_e'($urandom_range(1, 4));
    if (r < 10) begin
      // full relay header, exact minimum length now and then
      build_frame(($urandom_range(0, 3) == 0) ? HDR_BYTES :
                  $urandom_range(HDR_BYTES, HDR_BYTES + 33), 1'b1, pick_hop(), brk);
    end else if (r < 13) begin
      // relay header cut just short
      build_frame($urandom_range(HDR_BYTES - 8, HDR_BYTES - 1), 1'b1, pick_hop(), brk);
    end else if (r < 17) begin
      // runt frame ending well inside the header
      build_frame($urandom_range(1, 64), 1'b0, 32'd0, BRK_NONE);
    end else begin
      // long noise frame
      build_frame($urandom_range(HDR_BYTES, HDR_BYTES + 53), 1'b0, 32'd0, BRK_NONE);
    end
    send_frame();
  endtask

  // main sequence
  initial begin
    int p;
    in_if.valid    <= 1'b0;
    in_if.in_word  <= '0;
    in_if.in_bytes <= 4'd0;
    in_if.in_last  <= 1'b0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (p = 0; p < PHASES; p++) begin
      // register settings: reset values, all zero, all ones, random
      if (p > 0) begin
        wait_idle();
        case (p)
          1: begin
            write_register(REG_MAGIC, 32'h0000_0000);
            write_register(REG_KIND, 32'h0000_0000);
          end
          2: begin
            write_register(REG_MAGIC, 32'hFFFF_FFFF);
            write_register(REG_KIND, 32'h0000_00FF);
          end
          default: begin
            write_register(REG_MAGIC, $urandom);
            write_register(REG_KIND, $urandom_range(0, 255));
          end
        endcase
      end
      gaps_on = (p != PHASES - 1);

      if (p == 0) begin
        // relay frame of exact minimum length using the last hop slot
        build_frame(HDR_BYTES, 1'b1, HOP_SLOTS - 2, BRK_NONE);
        send_frame();
        // one-word frame with a zero byte count
        send_word({$urandom, $urandom}, 4'd0, 1'b1);
        // short word before the end, then an oversized count on the last
        send_word({$urandom, $urandom}, 4'd3, 1'b0);
        send_word({$urandom, $urandom}, 4'd12, 1'b1);
      end

      words_sent = 0;
      while (words_sent < RANDOM_WORDS / PHASES) begin
        if (p != PHASES - 1) gaps_on = ($urandom_range(0, 3) != 0);
        random_frame();
      end
    end

    wait_idle();
    relay_chk.close_out();
    if (relay_chk.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
